[design/lphash_pkg.sv]
// Package with constants, codes and types of the linear probing hash table.
`timescale 1ns / 1ps
`default_nettype none

package lphash_pkg;

  localparam int LOG2_DEPTH_DEF = 16;
  localparam int KEY_W          = 64;
  localparam int VAL_W          = 32;
  localparam int CFG_W          = 5;
  localparam int STATUS_W       = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [KEY_W-1:0] VACANT_KEY = '1;

  localparam logic [KEY_W-1:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX_MUL2 = 64'h94d049bb133111eb;

  localparam int SHIFT1 = 30;
  localparam int SHIFT2 = 27;
  localparam int SHIFT3 = 31;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RESERVED = 2'd2;

  localparam logic [1:0] ROUND_FIRST  = 2'd0;
  localparam logic [1:0] ROUND_SECOND = 2'd1;
  localparam logic [1:0] ROUND_LAST   = 2'd2;

  localparam logic [1:0] PHASE_LO_LO = 2'd0;
  localparam logic [1:0] PHASE_LO_HI = 2'd1;
  localparam logic [1:0] PHASE_HI_LO = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_XS,
    ST_MUL,
    ST_RD,
    ST_CHK
  } state_t;

endpackage

`default_nettype wire

[design/lphash_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lphash_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/linear_probe_hash_table_top.sv]
// Top level of the linear probing hash table with splitmix64 home slots.
//
// Channel  Ports                                          Handshake
// input    in_kind, in_key, in_value                      start and not busy
// result   out_found, out_result_value, out_status        out_strobe, one cycle
// config   cfg_wdata                                      cfg_we
//
// After reset a clearing pass writes every slot empty, with busy high.
// A transaction keeps busy high while it hashes the key on one shared 32x32 multiplier
// and then probes one slot at a time through the registered RAM read port.
// The result strobe follows in the cycle after the last probe; a reserved key
// answers in the next cycle without raising busy. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_top #(
  parameter int LOG2_DEPTH = lphash_pkg::LOG2_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_kind,
  input  wire logic [lphash_pkg::KEY_W-1:0]   in_key,
  input  wire logic [lphash_pkg::VAL_W-1:0]   in_value,
  output logic                                out_strobe,
  output logic                                out_found,
  output logic [lphash_pkg::VAL_W-1:0]        out_result_value,
  output logic [lphash_pkg::STATUS_W-1:0]     out_status,
  input  wire logic                           cfg_we,
  input  wire logic [lphash_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int KW = lphash_pkg::KEY_W;
  localparam int VW = lphash_pkg::VAL_W;
  localparam int EW = KW + VW;
  localparam int DEPTH = 1 << LOG2_DEPTH;

  lphash_pkg::state_t state_r, state_nxt;

  logic [lphash_pkg::CFG_W-1:0]    log2_size_r;
  logic [LOG2_DEPTH-1:0]           clr_r, clr_nxt;
  logic [LOG2_DEPTH-1:0]           cnt_r, cnt_nxt;
  logic [LOG2_DEPTH-1:0]           slot_r, slot_nxt;
  logic [1:0]                      round_r, round_nxt;
  logic [1:0]                      phase_r, phase_nxt;
  logic                            kind_r, kind_nxt;
  logic [KW-1:0]                   key_r, key_nxt;
  logic [VW-1:0]                   value_r, value_nxt;
  logic [KW-1:0]                   x_r, x_nxt;
  logic [KW-1:0]                   acc_r, acc_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [VW-1:0]                   out_value_r, out_value_nxt;
  logic [lphash_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [LOG2_DEPTH-1:0] mask;
  logic [KW-1:0]         mul_const;
  logic [31:0]           op_a;
  logic [31:0]           op_b;
  logic [63:0]           prod;
  logic [31:0]           acc_hi_sum;
  logic [KW-1:0]         xs_val;

  logic                  ram_we;
  logic [LOG2_DEPTH-1:0] ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;
  logic [KW-1:0]         rd_key;
  logic                  rd_empty;
  logic                  rd_match;

  always_comb begin
    for (int i = 0; i < LOG2_DEPTH; i++) begin
      mask[i] = (log2_size_r > lphash_pkg::CFG_W'(i));
    end
  end

  assign mul_const  = (round_r == lphash_pkg::ROUND_FIRST) ?
                      lphash_pkg::MIX_MUL1 : lphash_pkg::MIX_MUL2;
  assign op_a       = (phase_r == lphash_pkg::PHASE_HI_LO) ? x_r[63:32] : x_r[31:0];
  assign op_b       = (phase_r == lphash_pkg::PHASE_LO_HI) ? mul_const[63:32] :
                      mul_const[31:0];
  assign prod       = op_a * op_b;
  assign acc_hi_sum = acc_r[63:32] + prod[31:0];

  always_comb begin
    case (round_r)
      lphash_pkg::ROUND_FIRST:  xs_val = x_r ^ (x_r >> lphash_pkg::SHIFT1);
      lphash_pkg::ROUND_SECOND: xs_val = x_r ^ (x_r >> lphash_pkg::SHIFT2);
      default:                  xs_val = x_r ^ (x_r >> lphash_pkg::SHIFT3);
    endcase
  end

  assign rd_key   = ram_rdata[EW-1:VW];
  assign rd_empty = (rd_key == lphash_pkg::VACANT_KEY);
  assign rd_match = (rd_key == key_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    slot_nxt       = slot_r;
    round_nxt      = round_r;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    out_strobe_nxt = 1'b0;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = {key_r, value_r};

    case (state_r)
      lphash_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '1;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = lphash_pkg::ST_IDLE;
        end
      end
      lphash_pkg::ST_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          value_nxt = in_value;
          if (in_key == lphash_pkg::VACANT_KEY) begin
            out_strobe_nxt = 1'b1;
            out_found_nxt  = 1'b0;
            out_value_nxt  = '0;
            out_status_nxt = lphash_pkg::STATUS_RESERVED;
          end else begin
            x_nxt     = in_key + lphash_pkg::MIX_ADD;
            round_nxt = lphash_pkg::ROUND_FIRST;
            state_nxt = lphash_pkg::ST_XS;
          end
        end
      end
      lphash_pkg::ST_XS: begin
        x_nxt = xs_val;
        if (round_r == lphash_pkg::ROUND_LAST) begin
          slot_nxt  = xs_val[LOG2_DEPTH-1:0] & mask;
          cnt_nxt   = '0;
          state_nxt = lphash_pkg::ST_RD;
        end else begin
          phase_nxt = lphash_pkg::PHASE_LO_LO;
          state_nxt = lphash_pkg::ST_MUL;
        end
      end
      lphash_pkg::ST_MUL: begin
        case (phase_r)
          lphash_pkg::PHASE_LO_LO: begin
            acc_nxt   = prod;
            phase_nxt = lphash_pkg::PHASE_LO_HI;
          end
          lphash_pkg::PHASE_LO_HI: begin
            acc_nxt   = {acc_hi_sum, acc_r[31:0]};
            phase_nxt = lphash_pkg::PHASE_HI_LO;
          end
          default: begin
            x_nxt     = {acc_hi_sum, acc_r[31:0]};
            round_nxt = round_r + 1'b1;
            state_nxt = lphash_pkg::ST_XS;
          end
        endcase
      end
      lphash_pkg::ST_RD: begin
        state_nxt = lphash_pkg::ST_CHK;
      end
      lphash_pkg::ST_CHK: begin
        if (rd_empty) begin
          out_strobe_nxt = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = lphash_pkg::STATUS_OK;
          out_found_nxt  = (kind_r == lphash_pkg::KIND_INSERT);
          ram_we         = (kind_r == lphash_pkg::KIND_INSERT);
          state_nxt      = lphash_pkg::ST_IDLE;
        end else if (kind_r == lphash_pkg::KIND_LOOKUP && rd_match) begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b1;
          out_value_nxt  = ram_rdata[VW-1:0];
          out_status_nxt = lphash_pkg::STATUS_OK;
          state_nxt      = lphash_pkg::ST_IDLE;
        end else if (cnt_r == mask) begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b0;
          out_value_nxt  = '0;
          out_status_nxt = lphash_pkg::STATUS_FULL;
          state_nxt      = lphash_pkg::ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          slot_nxt  = (slot_r + 1'b1) & mask;
          state_nxt = lphash_pkg::ST_RD;
        end
      end
      default: begin
        state_nxt = lphash_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lphash_pkg::ST_CLEAR;
      clr_r        <= '0;
      cnt_r        <= '0;
      round_r      <= lphash_pkg::ROUND_FIRST;
      phase_r      <= lphash_pkg::PHASE_LO_LO;
      out_strobe_r <= 1'b0;
      log2_size_r  <= lphash_pkg::CFG_RESET;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      cnt_r        <= cnt_nxt;
      round_r      <= round_nxt;
      phase_r      <= phase_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        log2_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  lphash_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign busy             = (state_r != lphash_pkg::ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_found        = out_found_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire
